// ===== rtl/crms_pkg.sv =====
// Package for the charger retry mode sequencer: payload, config and state types, codes.
`timescale 1ns / 1ps

package crms_pkg;

   localparam logic [1:0] CSR_SOC_FULL_THRESHOLD = 2'd0;
   localparam logic [1:0] CSR_CURRENT_LIMIT      = 2'd1;
   localparam logic [1:0] CSR_SAMPLE_TICKS       = 2'd2;
   localparam logic [1:0] CSR_MAX_RETRIES        = 2'd3;

   localparam logic [7:0]  SOC_FULL_RESET     = 8'h61;
   localparam logic [15:0] CURRENT_LIMIT_RESET = 16'hc9;
   localparam logic [7:0]  SAMPLE_TICKS_RESET = 8'h14;
   localparam logic [1:0]  MAX_RETRIES_RESET  = 2'd3;

   localparam logic [1:0] MODE_IDLE      = 2'd0;
   localparam logic [1:0] MODE_CHARGING  = 2'd1;
   localparam logic [1:0] MODE_FAIL_RETRY = 2'd2;
   localparam logic [1:0] MODE_EXHAUSTED = 2'd3;

   localparam logic [3:0] PACK_STATE_EMPTY = 4'h2;
   localparam logic [1:0] RETRY_SATURATED  = 2'd3;

   typedef struct packed {
      logic [7:0]  charge_level;
      logic [15:0] pack_current;
      logic [7:0]  status_first;
      logic [7:0]  status_second;
      logic [7:0]  status_seventh;
      logic [7:0]  pack_fault_code;
      logic        fw_update_active;
   } req_type;

   typedef struct packed {
      logic [1:0] mode_code;
      logic       identify_pulse;
      logic       generic_fault;
      logic       trickle_active;
      logic       retry_failed_pulse;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  soc_full_threshold;
      logic [15:0] current_limit;
      logic [7:0]  sample_ticks;
      logic [1:0]  max_retries;
   } cfg_type;

   typedef struct packed {
      logic [7:0] window_count;
      logic [1:0] retry_count;
      logic       identify_done;
      logic       retry_failed_mark;
   } state_type;

endpackage

// ===== rtl/crms_step.sv =====
// Per-tick mode decision: decodes status bytes and computes result and next state.
`timescale 1ns / 1ps

module crms_step import crms_pkg::*; (
   input  req_type   req,
   input  cfg_type   cfg,
   input  state_type state_cur,
   output state_type state_nxt,
   output rsp_type   rsp
);

   logic       charging;
   logic       uvp;
   logic [3:0] nibble;
   logic [7:0] win_inc;
   logic       window_done;
   logic       exhausted;

   assign charging    = req.status_first[7];
   assign uvp         = req.status_second[1] | req.status_second[2];
   assign nibble      = req.status_seventh[3:0];
   assign win_inc     = state_cur.window_count + 8'd1;
   assign exhausted   = state_cur.retry_count >= cfg.max_retries;
   assign window_done = (win_inc == cfg.sample_ticks) && !exhausted;

   always_comb begin
      state_nxt = state_cur;
      rsp       = '0;
      rsp.mode_code = MODE_IDLE;
      if (req.fw_update_active) begin
         state_nxt.window_count      = '0;
         state_nxt.retry_count       = '0;
         state_nxt.retry_failed_mark = 1'b0;
      end else if (req.charge_level >= cfg.soc_full_threshold && req.pack_current == 16'd0) begin
         state_nxt.window_count = '0;
         state_nxt.retry_count  = '0;
         if (!state_cur.identify_done) begin
            state_nxt.identify_done = 1'b1;
            rsp.identify_pulse      = 1'b1;
         end
         rsp.mode_code = MODE_FAIL_RETRY;
      end else if (req.pack_current >= cfg.current_limit) begin
         state_nxt.window_count = '0;
         state_nxt.retry_count  = '0;
      end else begin
         state_nxt.window_count = win_inc;
         if (window_done) begin
            state_nxt.window_count = '0;
            state_nxt.retry_count  = state_cur.retry_count + 2'd1;
            if (charging && (req.charge_level != 8'd0 || !uvp)) begin
               state_nxt.retry_count = RETRY_SATURATED;
               rsp.generic_fault     = 1'b1;
               rsp.mode_code         = MODE_FAIL_RETRY;
            end else if (req.charge_level == 8'd0 && req.pack_fault_code == 8'd0 &&
                         nibble == PACK_STATE_EMPTY) begin
               state_nxt.retry_count = '0;
               rsp.trickle_active    = 1'b1;
            end else begin
               rsp.mode_code = MODE_CHARGING;
            end
         end else if (exhausted) begin
            state_nxt.window_count = '0;
            rsp.mode_code          = MODE_EXHAUSTED;
            if (!state_cur.retry_failed_mark) begin
               state_nxt.retry_failed_mark = 1'b1;
               rsp.retry_failed_pulse      = 1'b1;
            end
         end
      end
   end

endmodule

// ===== rtl/charger_retry_mode_sequencer.sv =====
// Charger retry mode sequencer top level: input register, decision logic, result register.
// Path: an accepted request goes to the input register, then to the result register.
// Throughput: one transaction per cycle unless rsp_ready stalls; the window and retry
//   counters update as an item moves from the input register into the result register.
// Reset (synchronous): both stages empty, counters and marks cleared, registers at defaults.
`timescale 1ns / 1ps

module charger_retry_mode_sequencer import crms_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   state_type state_ff, state_in;
   req_type   req_ff;
   logic      req_valid_ff;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff;
   logic      advance;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   crms_step u_step (
      .req       (req_ff),
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .rsp       (rsp_in)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SOC_FULL_THRESHOLD: cfg_in.soc_full_threshold = csr_wdata[7:0];
            CSR_CURRENT_LIMIT:      cfg_in.current_limit      = csr_wdata;
            CSR_SAMPLE_TICKS:       cfg_in.sample_ticks       = csr_wdata[7:0];
            CSR_MAX_RETRIES:        cfg_in.max_retries        = csr_wdata[1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.soc_full_threshold <= SOC_FULL_RESET;
         cfg_ff.current_limit      <= CURRENT_LIMIT_RESET;
         cfg_ff.sample_ticks       <= SAMPLE_TICKS_RESET;
         cfg_ff.max_retries        <= MAX_RETRIES_RESET;
         state_ff                  <= '0;
         req_valid_ff              <= 1'b0;
         rsp_valid_ff              <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= req_valid_ff;
            if (req_valid_ff) begin
               state_ff <= state_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         req_ff <= req_data;
      end
      if (advance && req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
